FILE: sv/bvle_pkg.sv
// Shared types and constants for the bounded value list engine.
// No dependencies; imported by the datapath, the controller and the top level.
package bvle_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_REM_FIRST = 3'd1,
        OP_REM_ALL   = 3'd2,
        OP_READ      = 3'd3,
        OP_REM_MAX   = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_COMPACT,
        S_READ
    } t_state;

    // what the datapath does with a beat coming back from the entry store
    typedef enum logic [2:0] {
        P_NONE,
        P_MATCH,
        P_MAX,
        P_SHIFT,
        P_COMPACT
    } t_proc;

    typedef enum logic [1:0] {
        D_ZERO,
        D_READ,
        D_BEST
    } t_dsel;

    typedef enum logic [1:0] {
        R_ZERO,
        R_ONE,
        R_REG,
        R_COUNT
    } t_rsel;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INC,
        C_DEC,
        C_CLEAR,
        C_WP
    } t_cnt;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [4:0]         removed_count;
        logic [4:0]         list_length;
    } t_resp;

    typedef struct packed {
        logic    latch;
        logic    insert;
        logic    read_pos;
        logic    begin_scan;
        logic    begin_shift;
        logic    begin_compact;
        logic    walk;
        t_proc   proc;
        logic    finish;
        t_status fin_status;
        t_dsel   data_sel;
        t_rsel   rem_sel;
        t_cnt    cnt_op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       is_empty;
        logic       is_full;
        logic       pos_ok;
        logic       found;
        logic       walk_done;
        logic       any_removed;
    } t_stat;

endpackage

FILE: sv/bvle_datapath.sv
// Datapath: entry store (oldest entry at address 0), count, walk pointers,
// match/max tracking and the result register. Depends on bvle_pkg.
module bvle_datapath #(
    parameter int MAX_ENTRIES = bvle_pkg::MAX_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bvle_pkg::t_req i_req,
    input  bvle_pkg::t_cmd i_cmd,
    output bvle_pkg::t_stat o_stat,
    output logic           o_valid,
    output bvle_pkg::t_resp o_result
);
    import bvle_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    logic signed [31:0] r_mem [MAX_ENTRIES];

    logic [2:0]         r_op;
    logic signed [31:0] r_value;
    logic [7:0]         r_pos;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_ptr;
    logic [CW-1:0]      r_left;
    logic               r_up;
    logic               r_dv;
    logic [IW-1:0]      r_didx;
    logic signed [31:0] r_rd_data;
    logic               r_found;
    logic [IW-1:0]      r_k;
    logic signed [31:0] r_best;
    logic [CW-1:0]      r_wp;
    logic [CW-1:0]      r_removed;
    logic               r_valid;
    t_resp              r_result;

    logic               w_issue;
    logic               w_re;
    logic [XW-1:0]      w_pos_x, w_cnt_x;
    logic               w_pos_ok;
    logic [IW-1:0]      w_rd_addr;
    logic               w_match;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;

    assign w_issue  = i_cmd.walk && (r_left != '0);
    assign w_re     = w_issue || i_cmd.read_pos;
    assign w_pos_x  = XW'(r_pos);
    assign w_cnt_x  = XW'(r_count);
    assign w_pos_ok = w_pos_x < w_cnt_x;
    // position 0 is the newest entry, which sits at address count-1
    assign w_rd_addr = i_cmd.read_pos ? IW'(w_cnt_x - w_pos_x - XW'(1)) : r_ptr;
    assign w_match  = (r_rd_data == r_value);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IW-1:0];
        w_wdata = r_value;
        if (i_cmd.insert) begin
            w_we = 1'b1;
        end else if (r_dv && i_cmd.proc == P_SHIFT) begin
            w_we    = 1'b1;
            w_waddr = r_didx - IW'(1);
            w_wdata = r_rd_data;
        end else if (r_dv && i_cmd.proc == P_COMPACT && !w_match) begin
            w_we    = 1'b1;
            w_waddr = r_wp[IW-1:0];
            w_wdata = r_rd_data;
        end
    end

    always_comb begin
        case (i_cmd.cnt_op)
            C_INC:   n_count = r_count + CW'(1);
            C_DEC:   n_count = r_count - CW'(1);
            C_CLEAR: n_count = '0;
            C_WP:    n_count = r_wp;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_dv    <= w_issue;
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_req.op;
            r_value <= i_req.value;
            r_pos   <= i_req.position;
        end

        r_didx <= r_ptr;
        if (w_issue) begin
            r_ptr  <= r_up ? r_ptr + IW'(1) : r_ptr - IW'(1);
            r_left <= r_left - CW'(1);
        end

        if (r_dv) begin
            case (i_cmd.proc)
                P_MATCH: begin
                    // walking down from the newest, so the first hit is the head-most
                    if (!r_found && w_match) begin
                        r_found <= 1'b1;
                        r_k     <= r_didx;
                    end
                end
                P_MAX: begin
                    if (!r_found || r_rd_data > r_best) begin
                        r_found <= 1'b1;
                        r_k     <= r_didx;
                        r_best  <= r_rd_data;
                    end
                end
                P_COMPACT: begin
                    if (w_match) begin
                        r_removed <= r_removed + CW'(1);
                    end else begin
                        r_wp <= r_wp + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.begin_scan) begin
            r_ptr   <= IW'(r_count - CW'(1));
            r_left  <= r_count;
            r_up    <= 1'b0;
            r_found <= 1'b0;
        end
        if (i_cmd.begin_shift) begin
            r_ptr  <= r_k + IW'(1);
            r_left <= r_count - CW'(1) - CW'(r_k);
            r_up   <= 1'b1;
        end
        if (i_cmd.begin_compact) begin
            r_ptr     <= '0;
            r_left    <= r_count;
            r_up      <= 1'b1;
            r_wp      <= '0;
            r_removed <= '0;
        end

        if (i_cmd.finish) begin
            r_result.status <= i_cmd.fin_status;
            case (i_cmd.data_sel)
                D_READ:  r_result.data <= r_rd_data;
                D_BEST:  r_result.data <= r_best;
                default: r_result.data <= '0;
            endcase
            case (i_cmd.rem_sel)
                R_ONE:   r_result.removed_count <= 5'd1;
                R_REG:   r_result.removed_count <= 5'(r_removed);
                R_COUNT: r_result.removed_count <= 5'(r_count);
                default: r_result.removed_count <= '0;
            endcase
            r_result.list_length <= 5'(n_count);
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.is_empty    = (r_count == '0);
    assign o_stat.is_full     = (r_count == CW'(MAX_ENTRIES));
    assign o_stat.pos_ok      = w_pos_ok;
    assign o_stat.found       = r_found;
    assign o_stat.walk_done   = (r_left == '0) && !r_dv;
    assign o_stat.any_removed = (r_removed != '0);

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_count < CW'(MAX_ENTRIES))
        else $error("insert into a full store");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv && i_cmd.proc == P_COMPACT) |-> CW'(r_didx) >= r_wp)
        else $error("compaction write pointer passed the read index");

    a_len_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> o_result.list_length == 5'(r_count))
        else $error("reported length differs from held count");
`endif

endmodule

FILE: sv/bvle_ctrl.sv
// Controller FSM: decodes the latched request and sequences the datapath walks.
// Depends on bvle_pkg.
module bvle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bvle_pkg::t_stat i_stat,
    output bvle_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import bvle_pkg::*;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if (i_stat.op == OP_INSERT) begin
                    w_cmd.finish = 1'b1;
                    if (i_stat.is_full) begin
                        w_cmd.fin_status = ST_FULL;
                    end else begin
                        w_cmd.insert = 1'b1;
                        w_cmd.cnt_op = C_INC;
                    end
                end else if (i_stat.op <= OP_CLEAR && i_stat.is_empty) begin
                    w_cmd.finish     = 1'b1;
                    w_cmd.fin_status = ST_EMPTY;
                end else begin
                    case (i_stat.op)
                        OP_REM_FIRST, OP_REM_MAX: begin
                            w_cmd.begin_scan = 1'b1;
                            n_state          = S_SCAN;
                        end
                        OP_REM_ALL: begin
                            w_cmd.begin_compact = 1'b1;
                            n_state             = S_COMPACT;
                        end
                        OP_READ: begin
                            if (i_stat.pos_ok) begin
                                w_cmd.read_pos = 1'b1;
                                n_state        = S_READ;
                            end else begin
                                w_cmd.finish     = 1'b1;
                                w_cmd.fin_status = ST_MISS;
                            end
                        end
                        OP_CLEAR: begin
                            w_cmd.finish  = 1'b1;
                            w_cmd.rem_sel = R_COUNT;
                            w_cmd.cnt_op  = C_CLEAR;
                        end
                        default: begin
                            // unused codes: no change, plain ok
                            w_cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_cmd.walk = 1'b1;
                w_cmd.proc = (i_stat.op == OP_REM_MAX) ? P_MAX : P_MATCH;
                if (i_stat.walk_done) begin
                    if (i_stat.found) begin
                        w_cmd.begin_shift = 1'b1;
                        n_state           = S_SHIFT;
                    end else begin
                        w_cmd.finish     = 1'b1;
                        w_cmd.fin_status = ST_MISS;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                w_cmd.walk = 1'b1;
                w_cmd.proc = P_SHIFT;
                if (i_stat.walk_done) begin
                    w_cmd.finish   = 1'b1;
                    w_cmd.rem_sel  = R_ONE;
                    w_cmd.data_sel = (i_stat.op == OP_REM_MAX) ? D_BEST : D_ZERO;
                    w_cmd.cnt_op   = C_DEC;
                    n_state        = S_IDLE;
                end
            end
            S_COMPACT: begin
                w_cmd.walk = 1'b1;
                w_cmd.proc = P_COMPACT;
                if (i_stat.walk_done) begin
                    w_cmd.finish     = 1'b1;
                    w_cmd.fin_status = i_stat.any_removed ? ST_OK : ST_MISS;
                    w_cmd.rem_sel    = R_REG;
                    w_cmd.cnt_op     = C_WP;
                    n_state          = S_IDLE;
                end
            end
            S_READ: begin
                w_cmd.finish   = 1'b1;
                w_cmd.data_sel = D_READ;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;
    assign busy  = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_finish_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> r_state == S_IDLE)
        else $error("result beat without return to idle");
`endif

endmodule

FILE: sv/bounded_value_list_engine.sv
// Result strobe: insert, clear, unused ops, empty list and read beyond length finish in dispatch;
// read via the read state; remove-first/-max walk in scan then shift; remove-all compacts.
// Throughput: one request at a time; busy drops in the cycle of the result beat, so the next
// start is taken at the edge that ends the strobe. The walks are set by the single store
// read port (one entry per cycle). Synchronous active-low reset empties the list.
module bounded_value_list_engine #(
    parameter int MAX_ENTRIES = bvle_pkg::MAX_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bvle_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output bvle_pkg::t_resp o_result
);
    import bvle_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bvle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    bvle_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
